[rtl/rma_pkg.sv]
// shared constants, types and helpers for the moving-average effect
package rma_pkg;

    localparam int MAX_TAPS     = 32;
    localparam int SAMPLE_BITS  = 12;
    localparam int TAP_BITS     = 8;
    localparam int SLOT_BITS    = $clog2(MAX_TAPS);
    localparam int FILL_BITS    = $clog2(MAX_TAPS + 1);
    localparam int TOTAL_BITS   = $clog2(MAX_TAPS * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int REM_BITS     = FILL_BITS + 1;
    localparam int STEP_BITS    = $clog2(TOTAL_BITS);
    localparam int DATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS    = 3;
    localparam int REG_IDX_BITS = 1;
    localparam int APB_BITS     = 32;

    localparam logic [TAP_BITS-1:0]     DEFAULT_TAPS = TAP_BITS'(2);
    localparam logic [REG_IDX_BITS-1:0] REG_EFFECT   = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_TAPS     = REG_IDX_BITS'(1);

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input item, read the ring slot
        logic update;    // update ring, total, fill, load the divider
        logic div_step;  // one restoring division step
        logic publish;   // move the result into the output register
    } rma_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic avg_mode;
        logic div_last;
        logic out_free;
    } rma_status_t;

    function automatic logic [TAP_BITS-1:0] clamp_taps(input logic [TAP_BITS-1:0] req);
        logic [TAP_BITS-1:0] res;
        res = req;
        if (req == '0)
            res = TAP_BITS'(1);
        else if (int'(req) > MAX_TAPS)
            res = TAP_BITS'(MAX_TAPS);
        return res;
    endfunction

endpackage

[rtl/rma_ctrl.sv]
// sequencing state machine for the moving-average effect
module rma_ctrl
    import rma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rma_status_t status,
    output rma_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.avg_mode ? ST_UPDATE : ST_DONE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/rma_datapath.sv]
// sample ring, running total, serial divider and output register
module rma_datapath
    import rma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rma_cmd_t               cmd,
    output rma_status_t            status,
    input  logic                   avg_sel,
    input  logic [TAP_BITS-1:0]    taps,
    input  logic                   clear,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample
);

    logic [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] old_reg;
    logic                   bypass_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   slot_next;
    logic [FILL_BITS-1:0]   fill_reg;
    logic [FILL_BITS-1:0]   fill_next;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [TOTAL_BITS-1:0]  total_next;
    logic [TOTAL_BITS-1:0]  quo_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [FILL_BITS-1:0]   divisor_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic                   full;
    logic [SLOT_BITS:0]     slot_inc;
    logic [REM_BITS-1:0]    trial;
    logic                   fits;

    always_comb
    begin
        full       = !({{(TAP_BITS-FILL_BITS){1'b0}}, fill_reg} < taps);
        fill_next  = full ? fill_reg : fill_reg + FILL_BITS'(1);
        total_next = total_reg
                   - (full ? TOTAL_BITS'(old_reg) : '0)
                   + TOTAL_BITS'(sample_reg);
        slot_inc   = {1'b0, slot_reg} + (SLOT_BITS+1)'(1);
        if (!({{(TAP_BITS-SLOT_BITS-1){1'b0}}, slot_inc} < taps))
            slot_next = '0;
        else
            slot_next = slot_inc[SLOT_BITS-1:0];
        // restoring step: bring down the next dividend bit
        trial = {rem_reg[REM_BITS-2:0], quo_reg[TOTAL_BITS-1]};
        fits  = !(trial < {1'b0, divisor_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            old_reg <= ring_mem[slot_reg];
        if (cmd.update)
            ring_mem[slot_reg] <= sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            bypass_reg <= !avg_sel;
        end
        if (cmd.update)
        begin
            quo_reg     <= total_next;
            rem_reg     <= '0;
            divisor_reg <= fill_next;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[TOTAL_BITS-2:0], fits};
            rem_reg <= fits ? trial - {1'b0, divisor_reg} : trial;
        end
        if (cmd.publish)
            out_reg <= bypass_reg ? sample_reg : quo_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                slot_reg  <= '0;
                fill_reg  <= '0;
                total_reg <= '0;
            end
            else if (cmd.update)
            begin
                slot_reg  <= slot_next;
                fill_reg  <= fill_next;
                total_reg <= total_next;
            end
            if (cmd.update)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + STEP_BITS'(1);
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.avg_mode = avg_sel;
    assign status.div_last = (step_reg == STEP_BITS'(TOTAL_BITS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;

endmodule

[rtl/ring_moving_average_effect_core.sv]
// top level of the moving-average audio effect with bypass
//
// one input item carries one sample on s_tdata, one output item carries one
// sample on m_tdata; every input item gives exactly one output item, in order
// registers over the apb-style port: effect_select at 0x0, tap_count at 0x4
// (tap_count reads back clamped to 1..32); a write to either clears the ring
// position, fill level and running total
// bypass: the captured sample goes through the done state into the output register
// moving average: capture, then ring, total and fill update, then the 17-step
// restoring divider (one quotient bit a cycle), then output load; in both modes
// a new item is taken only after the last one is published
// s_tready is high only while the sequencer waits for an item; a finished
// result sits in the output register, so the next item is taken while it
// waits, and a stalled receiver holds the block in its last step
// reset clears the sequencer, the output valid, the averaging state and sets
// bypass with two taps; ring contents are not cleared, and only slots written
// since the last clear are ever read back
module ring_moving_average_effect_core
    import rma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // in_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,   // out_sample
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [APB_BITS-1:0]  pwdata,
    output logic [APB_BITS-1:0]  prdata,
    output logic                 pready
);

    logic                    effect_reg;
    logic [TAP_BITS-1:0]     taps_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    clear;
    logic [SAMPLE_BITS-1:0]  out_sample;
    rma_cmd_t                cmd;
    rma_status_t             status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_BITS-1 -: REG_IDX_BITS];

    always_comb
    begin
        clear = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_EFFECT: clear = 1'b1;
                REG_TAPS:   clear = 1'b1;
                default:    clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_reg <= 1'b0;
            taps_reg   <= clamp_taps(DEFAULT_TAPS);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EFFECT: effect_reg <= pwdata[0];
                REG_TAPS:   taps_reg   <= clamp_taps(pwdata[TAP_BITS-1:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EFFECT: prdata = {{(APB_BITS-1){1'b0}}, effect_reg};
            REG_TAPS:   prdata = {{(APB_BITS-TAP_BITS){1'b0}}, taps_reg};
            default:    prdata = '0;
        endcase
    end

    rma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rma_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .avg_sel    (effect_reg),
        .taps       (taps_reg),
        .clear      (clear),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample)
    );

    assign m_tdata = {{(DATA_BITS-SAMPLE_BITS){1'b0}}, out_sample};

endmodule

[tb/ring_moving_average_effect_core_tb.sv]
// testbench for the moving-average effect core: predicted window means checked item by item
module ring_moving_average_effect_core_tb
    import rma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_GAP       = 14;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 250;
    localparam int TARGET_ITEMS  = 900;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    // predicts the output sample stream and checks what the block gives
    class average_scoreboard;
        bit                        averaging_on;
        int unsigned               taps;
        logic [SAMPLE_BITS-1:0]    ring [MAX_TAPS];
        int unsigned               slot;
        int unsigned               fill;
        logic [TOTAL_BITS-1:0]     total;
        logic [SAMPLE_BITS-1:0]    expected_samples [$];
        int unsigned               accepted;
        int unsigned               checked;
        int unsigned               mismatches;

        function new();
            averaging_on = 1'b0;
            taps         = int'(DEFAULT_TAPS);
            accepted     = 0;
            checked      = 0;
            mismatches   = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (ring[i])
                ring[i] = '0;
            slot  = 0;
            fill  = 0;
            total = '0;
        endfunction

        function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [APB_BITS-1:0] value);
            int unsigned req;
            req = int'(value[TAP_BITS-1:0]);
            if (idx == REG_EFFECT) begin
                averaging_on = value[0];
                clear_window();
            end
            else if (idx == REG_TAPS) begin
                if (req == 0)
                    taps = 1;
                else if (req > MAX_TAPS)
                    taps = MAX_TAPS;
                else
                    taps = req;
                clear_window();
            end
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] sample);
            accepted++;
            if (!averaging_on) begin
                expected_samples.push_back(sample);
                return;
            end
            // once the window is full the oldest sample drops out first
            if (fill < taps)
                fill++;
            else
                total = total - TOTAL_BITS'(ring[slot]);
            ring[slot] = sample;
            total = total + TOTAL_BITS'(sample);
            slot++;
            if (slot >= taps)
                slot = 0;
            expected_samples.push_back(SAMPLE_BITS'(int'(total) / int'(fill)));
        endfunction

        function void check_result(logic [DATA_BITS-1:0] data);
            logic [SAMPLE_BITS-1:0] want;
            checked++;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: output item 0x%0h with nothing expected", data);
                return;
            end
            want = expected_samples.pop_front();
            if (data !== DATA_BITS'(want)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: output item %0d out_sample expected 0x%03h got 0x%0h",
                             checked, want, data);
            end
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_BITS-1:0]  s_tdata;    // in_sample, zero padded
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_BITS-1:0]  m_tdata;    // out_sample, zero padded
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [APB_BITS-1:0]   pwdata;
    logic [APB_BITS-1:0]   prdata;
    logic                  pready;

    average_scoreboard sb = new();

    int unsigned cycle_count = 0;
    bit          send_gaps_on = 1'b1;
    bit          recv_gaps_on = 1'b1;
    bit          stream_active = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned settings_run = 0;
    int unsigned register_writes = 0;

    ring_moving_average_effect_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_count, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_register(input logic [REG_IDX_BITS-1:0] idx,
                                  input logic [APB_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        register_writes++;
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
        int unsigned gap;
        gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_BITS'(sample);
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(sample);
    endtask

    // stop offering, let every expected item arrive, then give the block time to settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        stream_active = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_list(input logic [SAMPLE_BITS-1:0] samples [$]);
        stream_active = 1'b1;
        foreach (samples[i])
            send_sample(samples[i]);
        wait_for_results();
        settings_run++;
    endtask

    // output side: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        int unsigned stall;
        int unsigned held;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && stream_active && sb.checked >= HOLD_AFTER)
            begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1'b1;
            end
            stall = recv_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        logic [SAMPLE_BITS-1:0] samples [$];
        int unsigned            count;
        int unsigned            pick;
        int unsigned            shape;
        logic [TAP_BITS-1:0]    req_taps;
        bit                     avg_bit;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass with reset settings, field extremes and alternating bits
        send_list('{12'h000, FULL_SCALE, 12'hAAA, 12'h555});

        // averaging with the default two taps
        write_register(REG_EFFECT, APB_BITS'(1));
        send_list('{FULL_SCALE, FULL_SCALE, 12'h000, FULL_SCALE, 12'h001});

        // zero taps behaves as one
        write_register(REG_TAPS, APB_BITS'(0));
        send_list('{FULL_SCALE, 12'h007, 12'h000});

        // three taps: fill ramp, wrap and steady-state subtraction
        write_register(REG_TAPS, APB_BITS'(3));
        send_list('{FULL_SCALE, FULL_SCALE, FULL_SCALE, 12'h000, 12'h000, 12'h000, FULL_SCALE});

        while (sb.accepted < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: req_taps = '0;
                1: req_taps = TAP_BITS'(1);
                2: req_taps = TAP_BITS'(MAX_TAPS);
                3: req_taps = TAP_BITS'(MAX_TAPS + 1);
                4: req_taps = '1;
                5: req_taps = TAP_BITS'($urandom_range(MAX_TAPS + 1, 255));
                default: req_taps = TAP_BITS'($urandom_range(2, MAX_TAPS - 1));
            endcase
            avg_bit = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    write_register(REG_TAPS, APB_BITS'(req_taps));
                    write_register(REG_EFFECT, APB_BITS'(avg_bit));
                end
                1:
                begin
                    write_register(REG_EFFECT, APB_BITS'(avg_bit));
                    write_register(REG_TAPS, APB_BITS'(req_taps));
                end
                2: write_register(REG_TAPS, APB_BITS'(req_taps));
                default: write_register(REG_EFFECT, APB_BITS'(avg_bit));
            endcase

            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 9);
            count = $urandom_range(10, 80);
            samples.delete();
            repeat (count)
            begin
                case (shape)
                    0: samples.push_back(FULL_SCALE);
                    1: samples.push_back($urandom_range(0, 1) ? FULL_SCALE : 12'h000);
                    default: samples.push_back(SAMPLE_BITS'($urandom_range(0, 4095)));
                endcase
            end
            send_list(samples);
        end

        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        wait_for_results();

        $display("covered %0d samples over %0d register settings (%0d writes), %0d outputs checked",
                 sb.accepted, settings_run, register_writes, sb.checked);
        $display("bypass, clamped tap counts, ring wrap, full-scale windows and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d items never arrived", sb.mismatches, sb.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule
